[design/mipsdec_pkg.sv]
`default_nettype none

package mipsdec_pkg;

	// Instruction word geometry
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned REG_W   = 5;
	localparam int unsigned OPC_W   = 6;
	localparam int unsigned KIND_W  = 5;
	localparam int unsigned SIZE_W  = 3;

	localparam logic [REG_W-1:0] LINK_REG = 5'd31;

	// Major opcodes (bits 31..26)
	localparam logic [OPC_W-1:0] OPC_SPECIAL = 6'h00;
	localparam logic [OPC_W-1:0] OPC_REGIMM  = 6'h01;
	localparam logic [OPC_W-1:0] OPC_J       = 6'h02;
	localparam logic [OPC_W-1:0] OPC_JAL     = 6'h03;
	localparam logic [OPC_W-1:0] OPC_BEQ     = 6'h04;
	localparam logic [OPC_W-1:0] OPC_BNE     = 6'h05;
	localparam logic [OPC_W-1:0] OPC_BLEZ    = 6'h06;
	localparam logic [OPC_W-1:0] OPC_BGTZ    = 6'h07;
	localparam logic [OPC_W-1:0] OPC_ADDI    = 6'h08;
	localparam logic [OPC_W-1:0] OPC_ADDIU   = 6'h09;
	localparam logic [OPC_W-1:0] OPC_SLTI    = 6'h0a;
	localparam logic [OPC_W-1:0] OPC_SLTIU   = 6'h0b;
	localparam logic [OPC_W-1:0] OPC_ANDI    = 6'h0c;
	localparam logic [OPC_W-1:0] OPC_ORI     = 6'h0d;
	localparam logic [OPC_W-1:0] OPC_XORI    = 6'h0e;
	localparam logic [OPC_W-1:0] OPC_LUI     = 6'h0f;
	localparam logic [OPC_W-1:0] OPC_COP0    = 6'h10;
	localparam logic [OPC_W-1:0] OPC_LB      = 6'h20;
	localparam logic [OPC_W-1:0] OPC_LH      = 6'h21;
	localparam logic [OPC_W-1:0] OPC_LWL     = 6'h22;
	localparam logic [OPC_W-1:0] OPC_LW      = 6'h23;
	localparam logic [OPC_W-1:0] OPC_LBU     = 6'h24;
	localparam logic [OPC_W-1:0] OPC_LHU     = 6'h25;
	localparam logic [OPC_W-1:0] OPC_LWR     = 6'h26;
	localparam logic [OPC_W-1:0] OPC_SB      = 6'h28;
	localparam logic [OPC_W-1:0] OPC_SH      = 6'h29;
	localparam logic [OPC_W-1:0] OPC_SWL     = 6'h2a;
	localparam logic [OPC_W-1:0] OPC_SW      = 6'h2b;
	localparam logic [OPC_W-1:0] OPC_SWR     = 6'h2e;
	localparam logic [OPC_W-1:0] OPC_CACHE   = 6'h2f;

	// SPECIAL function codes (bits 5..0)
	localparam logic [OPC_W-1:0] FN_SLL     = 6'h00;
	localparam logic [OPC_W-1:0] FN_SRL     = 6'h02;
	localparam logic [OPC_W-1:0] FN_SRA     = 6'h03;
	localparam logic [OPC_W-1:0] FN_SLLV    = 6'h04;
	localparam logic [OPC_W-1:0] FN_SRLV    = 6'h06;
	localparam logic [OPC_W-1:0] FN_SRAV    = 6'h07;
	localparam logic [OPC_W-1:0] FN_JR      = 6'h08;
	localparam logic [OPC_W-1:0] FN_JALR    = 6'h09;
	localparam logic [OPC_W-1:0] FN_MFHI    = 6'h10;
	localparam logic [OPC_W-1:0] FN_MTHI    = 6'h11;
	localparam logic [OPC_W-1:0] FN_MFLO    = 6'h12;
	localparam logic [OPC_W-1:0] FN_MTLO    = 6'h13;
	localparam logic [OPC_W-1:0] FN_MULT    = 6'h18;
	localparam logic [OPC_W-1:0] FN_MULTU   = 6'h19;
	localparam logic [OPC_W-1:0] FN_DIV     = 6'h1a;
	localparam logic [OPC_W-1:0] FN_DIVU    = 6'h1b;
	localparam logic [OPC_W-1:0] FN_ADD     = 6'h20;
	localparam logic [OPC_W-1:0] FN_ADDU    = 6'h21;
	localparam logic [OPC_W-1:0] FN_SUB     = 6'h22;
	localparam logic [OPC_W-1:0] FN_SUBU    = 6'h23;
	localparam logic [OPC_W-1:0] FN_AND     = 6'h24;
	localparam logic [OPC_W-1:0] FN_OR      = 6'h25;
	localparam logic [OPC_W-1:0] FN_XOR     = 6'h26;
	localparam logic [OPC_W-1:0] FN_NOR     = 6'h27;
	localparam logic [OPC_W-1:0] FN_SLT     = 6'h2a;
	localparam logic [OPC_W-1:0] FN_SLTU    = 6'h2b;

	// Micro-operation codes
	typedef enum logic [KIND_W-1:0] {
		OPK_EXEC   = 5'd0,
		OPK_SHL    = 5'd1,
		OPK_SHR    = 5'd2,
		OPK_SAR    = 5'd3,
		OPK_JUMPR  = 5'd4,
		OPK_MFHI   = 5'd5,
		OPK_MTHI   = 5'd6,
		OPK_MFLO   = 5'd7,
		OPK_MTLO   = 5'd8,
		OPK_MULT   = 5'd9,
		OPK_MULTU  = 5'd10,
		OPK_ADD_OV = 5'd11,
		OPK_ADD    = 5'd12,
		OPK_SUB_OV = 5'd13,
		OPK_SUB    = 5'd14,
		OPK_AND    = 5'd15,
		OPK_OR     = 5'd16,
		OPK_XOR    = 5'd17,
		OPK_NOR    = 5'd18,
		OPK_SLT    = 5'd19,
		OPK_SLTU   = 5'd20,
		OPK_BGEZ   = 5'd21,
		OPK_BLTZ   = 5'd22,
		OPK_JUMP   = 5'd23,
		OPK_BEQ    = 5'd24,
		OPK_BNE    = 5'd25,
		OPK_BLEZ   = 5'd26,
		OPK_BGTZ   = 5'd27,
		OPK_CONST  = 5'd28,
		OPK_LOAD   = 5'd29,
		OPK_STORE  = 5'd30
	} op_kind_t;

	// Access sizes
	localparam logic [SIZE_W-1:0] SIZE_NONE = 3'd0;
	localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
	localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
	localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

	// One decoded micro-operation
	typedef struct packed {
		op_kind_t            kind;
		logic [REG_W-1:0]    dest;
		logic [REG_W-1:0]    src1;
		logic [REG_W-1:0]    src2;
		logic                use_imm;
		logic [WORD_W-1:0]   imm;
		logic [SIZE_W-1:0]   size;
		logic                sext;
		logic                ends;
		logic [WORD_W-1:0]   word;
	} dec_t;

endpackage

`default_nettype wire

[design/mipsdec_decode.sv]
`default_nettype none

module mipsdec_decode (
	input  wire logic [mipsdec_pkg::WORD_W-1:0] word,
	output mipsdec_pkg::dec_t                   dec
);
	import mipsdec_pkg::*;

	logic [OPC_W-1:0]  opc;
	logic [OPC_W-1:0]  fn;
	logic [REG_W-1:0]  rs, rt, rd, shamt;
	logic [WORD_W-1:0] imm_sext, imm_zext, br_off, jmp_tgt, upper;

	// Field extraction
	assign opc      = word[31:26];
	assign fn       = word[5:0];
	assign rs       = word[25:21];
	assign rt       = word[20:16];
	assign rd       = word[15:11];
	assign shamt    = word[10:6];
	assign imm_sext = {{16{word[15]}}, word[15:0]};
	assign imm_zext = {16'h0000, word[15:0]};
	assign br_off   = {imm_sext[29:0], 2'b00};
	assign jmp_tgt  = {4'h0, word[25:0], 2'b00};
	assign upper    = {word[15:0], 16'h0000};

	always_comb begin
		dec         = '0;
		dec.kind    = OPK_EXEC;
		dec.dest    = rt;
		dec.src1    = rs;
		dec.src2    = rt;
		dec.use_imm = 1'b0;
		dec.imm     = '0;
		dec.size    = SIZE_NONE;
		dec.sext    = 1'b0;
		dec.ends    = 1'b0;
		dec.word    = word;

		unique case (opc)
			// Register-register group
			OPC_SPECIAL: begin
				dec.dest = rd;
				unique case (fn)
					FN_SLL, FN_SRL, FN_SRA: begin
						dec.kind    = (fn == FN_SLL) ? OPK_SHL :
							(fn == FN_SRL) ? OPK_SHR : OPK_SAR;
						dec.src1    = rt;
						dec.use_imm = 1'b1;
						dec.imm     = {27'd0, shamt};
					end
					FN_SLLV, FN_SRLV, FN_SRAV: begin
						dec.kind = (fn == FN_SLLV) ? OPK_SHL :
							(fn == FN_SRLV) ? OPK_SHR : OPK_SAR;
						dec.src1 = rt;
						dec.src2 = rs;
					end
					FN_JR: begin
						dec.kind = OPK_JUMPR;
						dec.dest = '0;
					end
					FN_JALR: begin
						dec.kind = OPK_JUMPR;
						dec.dest = (rd != '0) ? rd : LINK_REG;
					end
					FN_MFHI:  dec.kind = OPK_MFHI;
					FN_MTHI: begin
						dec.kind = OPK_MTHI;
						dec.dest = '0;
					end
					FN_MFLO:  dec.kind = OPK_MFLO;
					FN_MTLO: begin
						dec.kind = OPK_MTLO;
						dec.dest = '0;
					end
					FN_MULT: begin
						dec.kind = OPK_MULT;
						dec.dest = '0;
					end
					FN_MULTU: begin
						dec.kind = OPK_MULTU;
						dec.dest = '0;
					end
					FN_ADD:   dec.kind = OPK_ADD_OV;
					FN_ADDU:  dec.kind = OPK_ADD;
					FN_SUB:   dec.kind = OPK_SUB_OV;
					FN_SUBU:  dec.kind = OPK_SUB;
					FN_AND:   dec.kind = OPK_AND;
					FN_OR:    dec.kind = OPK_OR;
					FN_XOR:   dec.kind = OPK_XOR;
					FN_NOR:   dec.kind = OPK_NOR;
					FN_SLT:   dec.kind = OPK_SLT;
					FN_SLTU:  dec.kind = OPK_SLTU;
					// divides fall back but keep the block going
					FN_DIV, FN_DIVU: dec.kind = OPK_EXEC;
					default:  dec.ends = 1'b1;
				endcase
			end

			// Compare-with-zero branches, reserved forms end the block
			OPC_REGIMM: begin
				dec.dest = '0;
				dec.imm  = br_off;
				if (rt[3:1] != 3'b000) begin
					dec.ends = 1'b1;
				end else begin
					dec.kind = rt[0] ? OPK_BGEZ : OPK_BLTZ;
					dec.dest = rt[4] ? LINK_REG : '0;
					dec.src2 = '0;
				end
			end

			OPC_J, OPC_JAL: begin
				dec.kind = OPK_JUMP;
				dec.imm  = jmp_tgt;
				dec.dest = (opc == OPC_JAL) ? LINK_REG : '0;
			end

			OPC_BEQ: begin
				dec.kind = OPK_BEQ;
				dec.dest = '0;
				dec.imm  = br_off;
			end
			OPC_BNE: begin
				dec.kind = OPK_BNE;
				dec.dest = '0;
				dec.imm  = br_off;
			end
			OPC_BLEZ: begin
				dec.kind = OPK_BLEZ;
				dec.dest = '0;
				dec.src2 = '0;
				dec.imm  = br_off;
			end
			OPC_BGTZ: begin
				dec.kind = OPK_BGTZ;
				dec.dest = '0;
				dec.src2 = '0;
				dec.imm  = br_off;
			end

			// Immediate arithmetic and logic
			OPC_ADDI, OPC_ADDIU, OPC_SLTI, OPC_SLTIU: begin
				dec.kind    = (opc == OPC_ADDI)  ? OPK_ADD_OV :
					(opc == OPC_ADDIU) ? OPK_ADD :
					(opc == OPC_SLTI)  ? OPK_SLT : OPK_SLTU;
				dec.use_imm = 1'b1;
				dec.imm     = imm_sext;
			end
			OPC_ANDI, OPC_ORI, OPC_XORI: begin
				dec.kind    = (opc == OPC_ANDI) ? OPK_AND :
					(opc == OPC_ORI) ? OPK_OR : OPK_XOR;
				dec.use_imm = 1'b1;
				dec.imm     = imm_zext;
			end
			OPC_LUI: begin
				dec.kind    = OPK_CONST;
				dec.use_imm = 1'b1;
				dec.imm     = upper;
			end

			// Loads
			OPC_LB, OPC_LH, OPC_LW, OPC_LBU, OPC_LHU: begin
				dec.kind    = OPK_LOAD;
				dec.use_imm = 1'b1;
				dec.imm     = imm_sext;
				dec.size    = (opc == OPC_LW) ? SIZE_WORD :
					opc[0] ? SIZE_HALF : SIZE_BYTE;
				dec.sext    = (opc == OPC_LB) || (opc == OPC_LH) || (opc == OPC_LW);
			end

			// Stores
			OPC_SB, OPC_SH, OPC_SW: begin
				dec.kind    = OPK_STORE;
				dec.dest    = '0;
				dec.use_imm = 1'b1;
				dec.imm     = imm_sext;
				dec.size    = (opc == OPC_SW) ? SIZE_WORD :
					(opc == OPC_SH) ? SIZE_HALF : SIZE_BYTE;
			end

			// Unaligned accesses and cache ops fall back, block continues
			OPC_LWL, OPC_LWR, OPC_SWL, OPC_SWR, OPC_CACHE: begin
				dec.imm = imm_sext;
			end

			// Coprocessor 0: only moves from it keep the block going
			OPC_COP0: begin
				dec.imm  = imm_sext;
				dec.ends = (rs != '0);
			end

			default: begin
				dec.imm  = imm_sext;
				dec.ends = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/mips_instruction_to_ir_decoder_core.sv]
`default_nettype none

// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------------
// instr     in         instr_valid / instr_stall  instr_word
// dec       out        dec_valid / dec_stall      op_kind .. orig_word (one decoded op)
//
// An accepted word is loaded into the input register, then its decode is loaded into the
// output register. One word is taken every cycle while instr_stall is low; the single
// decode pass lies between the two registers.
// arst_n clears both valid flags; payload registers are not reset.
// While dec_stall holds a word, the input register still takes one more word if it is empty.
module mips_instruction_to_ir_decoder_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,

	input  wire logic                                  instr_valid,
	output      logic                                  instr_stall,
	input  wire logic [mipsdec_pkg::WORD_W-1:0]        instr_word,

	output      logic                                  dec_valid,
	input  wire logic                                  dec_stall,
	output      logic [mipsdec_pkg::KIND_W-1:0]        op_kind,
	output      logic [mipsdec_pkg::REG_W-1:0]         dest_reg,
	output      logic [mipsdec_pkg::REG_W-1:0]         first_source,
	output      logic [mipsdec_pkg::REG_W-1:0]         second_source,
	output      logic                                  uses_immediate,
	output      logic [mipsdec_pkg::WORD_W-1:0]        imm_value,
	output      logic [mipsdec_pkg::SIZE_W-1:0]        access_bytes,
	output      logic                                  sign_extend,
	output      logic                                  end_of_block,
	output      logic [mipsdec_pkg::WORD_W-1:0]        orig_word
);
	import mipsdec_pkg::*;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              valid_s2;
	dec_t              dec_s2;
	dec_t              dec_next;
	logic              adv_s2;
	logic              adv_s1;

	// Output register takes a new word when empty or being drained
	assign adv_s2      = !valid_s2 || !dec_stall;
	// Input register frees up when its word moves on
	assign adv_s1      = !valid_s1 || adv_s2;
	assign instr_stall = !adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= instr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && instr_valid) begin
			word_s1 <= instr_word;
		end
	end

	// Decode logic
	mipsdec_decode u_decode (
		.word (word_s1),
		.dec  (dec_next)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			dec_s2 <= dec_next;
		end
	end

	assign dec_valid      = valid_s2;
	assign op_kind        = dec_s2.kind;
	assign dest_reg       = dec_s2.dest;
	assign first_source   = dec_s2.src1;
	assign second_source  = dec_s2.src2;
	assign uses_immediate = dec_s2.use_imm;
	assign imm_value      = dec_s2.imm;
	assign access_bytes   = dec_s2.size;
	assign sign_extend    = dec_s2.sext;
	assign end_of_block   = dec_s2.ends;
	assign orig_word      = dec_s2.word;

endmodule

`default_nettype wire

[design/mipsdec_checker.sv]
`default_nettype none

module mipsdec_checker (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  instr_valid,
	input  wire logic                                  instr_stall,
	input  wire logic [mipsdec_pkg::WORD_W-1:0]        instr_word,
	input  wire logic                                  dec_valid,
	input  wire logic                                  dec_stall,
	input  wire logic [mipsdec_pkg::KIND_W-1:0]        op_kind,
	input  wire logic [mipsdec_pkg::REG_W-1:0]         dest_reg,
	input  wire logic [mipsdec_pkg::REG_W-1:0]         first_source,
	input  wire logic [mipsdec_pkg::REG_W-1:0]         second_source,
	input  wire logic                                  uses_immediate,
	input  wire logic [mipsdec_pkg::WORD_W-1:0]        imm_value,
	input  wire logic [mipsdec_pkg::SIZE_W-1:0]        access_bytes,
	input  wire logic                                  sign_extend,
	input  wire logic                                  end_of_block,
	input  wire logic [mipsdec_pkg::WORD_W-1:0]        orig_word
);
	import mipsdec_pkg::*;

	// Nothing comes out right after a reset edge
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !dec_valid)
		else $error("decoded word valid during reset");

	// A stalled decoded word stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> dec_valid && $stable(orig_word) && $stable(op_kind)
			&& $stable(imm_value) && $stable(dest_reg))
		else $error("decoded word changed under stall");

	// Memory size only for loads and stores, and they always carry one
	a_size_kind: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid |-> ((access_bytes != SIZE_NONE) ==
			(op_kind == OPK_LOAD || op_kind == OPK_STORE)))
		else $error("access size does not match operation");

	// Jump target comes straight from the passed-through word
	a_jump_target: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && op_kind == OPK_JUMP |->
			imm_value == {4'h0, orig_word[25:0], 2'b00} && !uses_immediate)
		else $error("jump target not derived from instruction word");

	// Sign extension is a load attribute only
	a_sext_load: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && sign_extend |-> op_kind == OPK_LOAD && !end_of_block)
		else $error("sign extend on a non-load");

endmodule

bind mips_instruction_to_ir_decoder_core mipsdec_checker u_mipsdec_checker (.*);

`default_nettype wire
